### design/markup_token_lexer_macros.svh
// assertion macros shared by the lexer modules
// expects clk and rst_n in the scope of the module that expands them
`ifndef MARKUP_TOKEN_LEXER_MACROS_SVH
`define MARKUP_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mtl_pkg.sv
// shared types and constants of the markup token lexer
// no dependencies; used by the token interface and all lexer modules
`timescale 1ns / 1ps
`default_nettype none

package mtl_pkg;

    localparam int MTL_POSITION_WIDTH = 16;
    localparam int MTL_QUEUE_DEPTH    = 4;
    localparam int FIELD_W            = 16;
    localparam int KIND_W             = 5;

    typedef logic [KIND_W-1:0] mtl_kind_t;

    // token kinds above the sixteen symbol codes
    localparam mtl_kind_t K_MINUS   = 5'd16;
    localparam mtl_kind_t K_SLASH   = 5'd17;
    localparam mtl_kind_t K_STRING  = 5'd18;
    localparam mtl_kind_t K_IDENT   = 5'd19;
    localparam mtl_kind_t K_GENCOM  = 5'd20;
    localparam mtl_kind_t K_END     = 5'd21;
    localparam mtl_kind_t K_ILLEGAL = 5'd22;

    // one token record as it leaves the block
    typedef struct packed {
        mtl_kind_t          token_kind;
        logic [FIELD_W-1:0] text_offset;
        logic [FIELD_W-1:0] text_length;
        logic [FIELD_W-1:0] token_line;
        logic [FIELD_W-1:0] token_column;
        logic               last_of_run;
    } mtl_token_t;

    // up to two records produced by one text byte
    typedef struct packed {
        logic [1:0] count;
        mtl_token_t rec0;
        mtl_token_t rec1;
    } mtl_push_t;

endpackage

`default_nettype wire

### design/mtl_if.sv
// valid/ready channel interfaces for text bytes and token records
// depends on mtl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mtl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface mtl_token_if;
    import mtl_pkg::*;

    logic               valid;
    logic               ready;
    mtl_kind_t          token_kind;
    logic [FIELD_W-1:0] text_offset;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] token_line;
    logic [FIELD_W-1:0] token_column;
    logic               last_of_run;

    modport source (
        output valid, output token_kind, output text_offset, output text_length,
        output token_line, output token_column, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input text_offset, input text_length,
        input token_line, input token_column, input last_of_run, output ready
    );
endinterface

`default_nettype wire

### design/mtl_lexer_core.sv
// lexer state and single-pass scan logic: one byte in, up to two records out
// depends on mtl_pkg and markup_token_lexer_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module mtl_lexer_core #(
    parameter int POSITION_WIDTH = mtl_pkg::MTL_POSITION_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       text_byte,
    output mtl_pkg::mtl_push_t    push
);
    import mtl_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam logic [PW-1:0] POS_MAX = '1;
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";

    typedef enum logic [9:0] {
        MODE_IDLE      = 10'b00_0000_0001,
        MODE_IDENT     = 10'b00_0000_0010,
        MODE_STRING    = 10'b00_0000_0100,
        MODE_LITERAL   = 10'b00_0000_1000,
        MODE_GENCOM    = 10'b00_0001_0000,
        MODE_LINECOM   = 10'b00_0010_0000,
        MODE_BLOCKCOM  = 10'b00_0100_0000,
        MODE_BLOCKSTAR = 10'b00_1000_0000,
        MODE_MINUS     = 10'b01_0000_0000,
        MODE_SLASH     = 10'b10_0000_0000
    } mode_t;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] x);
        return (x == POS_MAX) ? POS_MAX : x + POS_ONE;
    endfunction

    function automatic logic [PW-1:0] diff(input logic [PW-1:0] hi, input logic [PW-1:0] lo);
        return (hi >= lo) ? hi - lo : '0;
    endfunction

    // symbol table: hit bit and symbol code
    function automatic logic [4:0] sym_lookup(input logic [7:0] c);
        case (c)
            "{":     return {1'b1, 4'd0};
            "}":     return {1'b1, 4'd1};
            "(":     return {1'b1, 4'd2};
            ")":     return {1'b1, 4'd3};
            "[":     return {1'b1, 4'd4};
            "]":     return {1'b1, 4'd5};
            ":":     return {1'b1, 4'd6};
            "=":     return {1'b1, 4'd7};
            ";":     return {1'b1, 4'd8};
            ",":     return {1'b1, 4'd9};
            ".":     return {1'b1, 4'd10};
            "&":     return {1'b1, 4'd11};
            "?":     return {1'b1, 4'd12};
            "+":     return {1'b1, 4'd13};
            "*":     return {1'b1, 4'd14};
            "%":     return {1'b1, 4'd15};
            default: return 5'd0;
        endcase
    endfunction

    function automatic mtl_token_t make_rec(
        input mtl_kind_t     kind,
        input logic [PW-1:0] off,
        input logic [PW-1:0] len,
        input logic [PW-1:0] ln,
        input logic [PW-1:0] cl
    );
        mtl_token_t r;
        r.token_kind   = kind;
        r.text_offset  = FIELD_W'(off);
        r.text_length  = FIELD_W'(len);
        r.token_line   = FIELD_W'(ln);
        r.token_column = FIELD_W'(cl);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    mode_t         mode_reg, mode_next;
    logic [7:0]    quote_reg, quote_next;
    logic [PW-1:0] byte_position_reg, line_count_reg, column_count_reg;
    logic [PW-1:0] start_offset_reg, start_offset_next;
    logic [PW-1:0] start_line_reg, start_line_next;
    logic [PW-1:0] start_column_reg, start_column_next;
    logic [PW-1:0] trimmed_reg, trimmed_next;

    logic [PW-1:0] pos, pos_inc, line_now, col_now;
    logic          is_lf, is_nul, is_alpha, is_trim;
    logic [4:0]    sym;
    logic          idle_ws, idle_quote, idle_lit, idle_emit, idle_start;
    mode_t         idle_mode;
    mtl_token_t    idle_rec, pre_rec;
    logic          pre_emit, run_idle, end_seen;
    logic [1:0]    rec_count;

    // position of this byte and counters after it
    always_comb
    begin
        is_lf    = (text_byte == CH_LF);
        is_nul   = (text_byte == CH_NUL);
        is_alpha = ((text_byte >= "A") && (text_byte <= "Z")) ||
                   ((text_byte >= "a") && (text_byte <= "z")) || (text_byte == CH_UNDER);
        is_trim  = text_byte inside {CH_SPACE, [CH_TAB:CH_CR]};
        pos      = byte_position_reg;
        pos_inc  = sat_inc(pos);
        line_now = is_lf ? sat_inc(line_count_reg) : line_count_reg;
        col_now  = is_lf ? '0 : sat_inc(column_count_reg);
    end

    // decode of a byte seen between tokens
    always_comb
    begin
        sym        = sym_lookup(text_byte);
        idle_ws    = text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
        idle_quote = (text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE);
        idle_start = !idle_ws && !sym[4];
        idle_lit   = 1'b0;
        idle_emit  = 1'b0;
        idle_mode  = MODE_IDLE;
        idle_rec   = make_rec(K_ILLEGAL, pos, POS_ONE, line_now, col_now);
        if (idle_ws)
        begin
            idle_emit = 1'b0;
        end
        else if (sym[4])
        begin
            idle_emit = 1'b1;
            idle_rec  = make_rec({1'b0, sym[3:0]}, pos, POS_ONE, line_now, col_now);
        end
        else if (is_nul)
        begin
            idle_emit = 1'b1;
            idle_rec  = make_rec(K_END, pos, '0, line_now, col_now);
        end
        else if (idle_quote)
        begin
            idle_mode = MODE_STRING;
        end
        else if (text_byte == CH_MINUS)
        begin
            idle_mode = MODE_MINUS;
        end
        else if (text_byte == CH_SLASH)
        begin
            idle_mode = MODE_SLASH;
        end
        else if (is_alpha)
        begin
            idle_mode = MODE_IDENT;
        end
        else if (text_byte inside {[8'h21:8'h7E]})
        begin
            idle_lit  = 1'b1;
            idle_mode = MODE_LITERAL;
        end
        else
        begin
            idle_emit = 1'b1;
        end
    end

    // per-mode scan step, then the idle decode when the byte starts fresh
    always_comb
    begin
        pre_emit          = 1'b0;
        pre_rec           = make_rec(K_STRING, start_offset_reg, trimmed_reg,
                                     start_line_reg, start_column_reg);
        run_idle          = 1'b0;
        mode_next         = mode_reg;
        quote_next        = quote_reg;
        start_offset_next = start_offset_reg;
        start_line_next   = start_line_reg;
        start_column_next = start_column_reg;
        trimmed_next      = trimmed_reg;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (!is_alpha)
                begin
                    pre_emit = 1'b1;
                    pre_rec  = make_rec(K_IDENT, start_offset_reg, diff(pos, start_offset_reg),
                                        start_line_reg, start_column_reg);
                    run_idle = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if ((text_byte == quote_reg) || is_nul)
                begin
                    pre_emit  = 1'b1;
                    pre_rec   = make_rec(K_STRING, start_offset_reg, diff(pos, start_offset_reg),
                                         start_line_reg, start_column_reg);
                    mode_next = MODE_IDLE;
                    run_idle  = is_nul;
                end
            end
            MODE_LITERAL:
            begin
                if (text_byte inside {CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LF, CH_NUL})
                begin
                    pre_emit = 1'b1;
                    run_idle = 1'b1;
                end
                else if (!is_trim)
                begin
                    trimmed_next = diff(pos_inc, start_offset_reg);
                end
            end
            MODE_GENCOM:
            begin
                if (is_lf || is_nul)
                begin
                    pre_emit = 1'b1;
                    pre_rec  = make_rec(K_GENCOM, start_offset_reg, diff(pos, start_offset_reg),
                                        start_line_reg, start_column_reg);
                    run_idle = 1'b1;
                end
            end
            MODE_LINECOM:
            begin
                run_idle = is_lf || is_nul;
            end
            MODE_BLOCKCOM, MODE_BLOCKSTAR:
            begin
                if (is_nul)
                begin
                    run_idle = 1'b1;
                end
                else if ((mode_reg == MODE_BLOCKSTAR) && (text_byte == CH_SLASH))
                begin
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = (text_byte == CH_STAR) ? MODE_BLOCKSTAR : MODE_BLOCKCOM;
                end
            end
            MODE_MINUS:
            begin
                if (text_byte == CH_MINUS)
                begin
                    start_offset_next = pos_inc;
                    mode_next         = MODE_GENCOM;
                end
                else
                begin
                    pre_emit = 1'b1;
                    pre_rec  = make_rec(K_MINUS, start_offset_reg, POS_ONE,
                                        start_line_reg, start_column_reg);
                    run_idle = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (text_byte == CH_SLASH)
                begin
                    mode_next = MODE_LINECOM;
                end
                else if (text_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCKCOM;
                end
                else
                begin
                    pre_emit = 1'b1;
                    pre_rec  = make_rec(K_SLASH, start_offset_reg, POS_ONE,
                                        start_line_reg, start_column_reg);
                    run_idle = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle)
        begin
            mode_next = idle_mode;
            if (idle_start)
            begin
                start_offset_next = idle_quote ? pos_inc : pos;
                start_line_next   = line_now;
                start_column_next = col_now;
            end
            if (idle_quote)
            begin
                quote_next = text_byte;
            end
            if (idle_lit)
            begin
                trimmed_next = (pos == POS_MAX) ? '0 : POS_ONE;
            end
        end
    end

    // record packing and end-of-text detection
    always_comb
    begin
        end_seen  = run_idle && is_nul;
        rec_count = {1'b0, pre_emit} + {1'b0, run_idle && idle_emit};
        push.rec0 = pre_emit ? pre_rec : idle_rec;
        push.rec1 = idle_rec;
        if (rec_count == 2'd2)
        begin
            push.rec1.last_of_run = 1'b1;
        end
        else
        begin
            push.rec0.last_of_run = 1'b1;
        end
        push.count = fire ? rec_count : 2'd0;
    end

    // lexer state; the end token returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            quote_reg         <= '0;
            byte_position_reg <= '0;
            line_count_reg    <= POS_ONE;
            column_count_reg  <= '0;
            start_offset_reg  <= '0;
            start_line_reg    <= POS_ONE;
            start_column_reg  <= '0;
            trimmed_reg       <= '0;
        end
        else if (fire)
        begin
            if (end_seen)
            begin
                mode_reg          <= MODE_IDLE;
                quote_reg         <= '0;
                byte_position_reg <= '0;
                line_count_reg    <= POS_ONE;
                column_count_reg  <= '0;
                start_offset_reg  <= '0;
                start_line_reg    <= POS_ONE;
                start_column_reg  <= '0;
                trimmed_reg       <= '0;
            end
            else
            begin
                mode_reg          <= mode_next;
                quote_reg         <= quote_next;
                byte_position_reg <= pos_inc;
                line_count_reg    <= line_now;
                column_count_reg  <= col_now;
                start_offset_reg  <= start_offset_next;
                start_line_reg    <= start_line_next;
                start_column_reg  <= start_column_next;
                trimmed_reg       <= trimmed_next;
            end
        end
    end

`include "markup_token_lexer_macros.svh"

    `MTL_ASSERT_NEXT(a_end_clears, fire && (text_byte == CH_NUL), (byte_position_reg == '0) && (mode_reg == MODE_IDLE), "end of text did not clear lexer state")
    `MTL_ASSERT_NOW(a_pair_needs_pending, push.count == 2'd2, mode_reg != MODE_IDLE, "two records from an idle lexer")
    `MTL_ASSERT_NEXT(a_line_holds, fire && (text_byte != CH_LF) && (text_byte != CH_NUL), line_count_reg == $past(line_count_reg), "line count moved without a newline")

endmodule

`default_nettype wire

### design/mtl_token_fifo.sv
// small token queue that takes up to two records per cycle while it has room for a pair, gives one per beat
// depends on mtl_pkg, mtl_if and markup_token_lexer_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module mtl_token_fifo #(
    parameter int DEPTH = mtl_pkg::MTL_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mtl_pkg::mtl_push_t push,
    output logic                   room,
    mtl_token_if.source            token_out
);
    import mtl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    mtl_token_t         q_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   tail_plus1;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    mtl_token_t         head_rec;

    // room for a full pair, judged on stored entries only
    assign room = (count_reg <= CNT_W'(DEPTH - 2));

    // head entry drives the output beat
    always_comb
    begin
        head_rec               = q_reg[head_reg];
        token_out.valid        = (count_reg != '0);
        token_out.token_kind   = head_rec.token_kind;
        token_out.text_offset  = head_rec.text_offset;
        token_out.text_length  = head_rec.text_length;
        token_out.token_line   = head_rec.token_line;
        token_out.token_column = head_rec.token_column;
        token_out.last_of_run  = head_rec.last_of_run;
    end

    // pointer and count update
    always_comb
    begin
        pop        = token_out.valid && token_out.ready;
        tail_plus1 = wrap_inc(tail_reg);
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = wrap_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[tail_reg] <= push.rec0;
        end
        if (push.count == 2'd2)
        begin
            q_reg[tail_plus1] <= push.rec1;
        end
    end

`include "markup_token_lexer_macros.svh"

    `MTL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "token queue count beyond depth")
    `MTL_ASSERT_NOW(a_push_with_room, push.count != 2'd0, room, "records pushed without room")
    `MTL_ASSERT_NOW(a_push_at_most_two, 1'b1, push.count != 2'd3, "more than two records in one push")

endmodule

`default_nettype wire

### design/markup_token_lexer.sv
// Markup token lexer, top level.
// text_in takes one text byte per beat; a zero byte ends the text. token_out
// gives one token record per beat: kind, offset and length of the token
// text, start line and column, and last_of_run on the final record that a
// byte causes. Whitespace and line and block comments give no records; a
// comment opened by two minus signs gives one. An accepted byte waits in the
// input register until the queue has room for a pair, is scanned, and its
// records are written into the token queue, whose head drives token_out.
// Throughput: one byte per cycle while the queue has room for a pair. A byte
// that closes a pending token and also yields one of its own makes two
// records, which leave on separate beats; the token queue takes both at once.
// The input register refills in the cycle its byte is scanned. The queue
// holds four records and a byte is scanned only while it has room for a pair,
// so a stalled receiver holds the byte in the input register and stops input
// once three records are waiting.
// Reset clears the scan state, counters and queue; no clearing pass is needed.
// After the end token the scan state and counters return to their reset values.
// depends on mtl_pkg, mtl_if, mtl_lexer_core and mtl_token_fifo
`timescale 1ns / 1ps
`default_nettype none

module markup_token_lexer #(
    parameter int POSITION_WIDTH = mtl_pkg::MTL_POSITION_WIDTH,
    parameter int QUEUE_DEPTH    = mtl_pkg::MTL_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mtl_byte_if.sink     text_in,
    mtl_token_if.source  token_out
);
    import mtl_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       accept, fire, room;
    mtl_push_t  push;

    // input register: refills in the same cycle the held byte is scanned
    always_comb
    begin
        fire          = in_valid_reg && room;
        text_in.ready = !in_valid_reg || room;
        accept        = text_in.valid && text_in.ready;
        in_valid_next = accept || (in_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= text_in.text_byte;
        end
    end

    // scan stage
    mtl_lexer_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .text_byte (in_byte_reg),
        .push      (push)
    );

    // result queue
    mtl_token_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .token_out (token_out)
    );

endmodule

`default_nettype wire
